/* rtl/ecmt_pkg.sv */
// Package for the event cluster moment tracker.
// Shared constants and payload types; no dependencies.
package ecmt_pkg;

  localparam int MomentSlots    = 128;
  localparam int ActivitySlots  = 128;
  localparam int MomentSlotUs   = 100;
  localparam int ActivitySlotUs = 1000;
  localparam int CoordBits      = 7;

  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 20;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] RegMinActivity = 2'd0;
  localparam logic [CfgAddrW-1:0] RegPathInterval = 2'd1;
  localparam logic [CfgAddrW-1:0] RegPathDistSq = 2'd2;

  // Item kinds
  localparam logic FuncEvent = 1'b0;
  localparam logic FuncTick  = 1'b1;

  // pi in Q12
  localparam logic [13:0] PiQ12 = 14'd12868;

  typedef struct packed {
    logic        func;
    logic [30:0] timestamp;
    logic [CoordBits-1:0] event_x;
    logic [CoordBits-1:0] event_y;
  } in_item_t;

  typedef struct packed {
    logic [14:0] centroid_x;
    logic [14:0] centroid_y;
    logic [15:0] spread_x;
    logic [15:0] spread_y;
    logic [23:0] activity;
    logic [30:0] lifetime;
    logic        path_point_added;
  } out_item_t;

endpackage

/* rtl/ecmt_if.sv */
// Valid/ready stream interface carrying one payload.
// Depends on nothing but its type parameter.
interface ecmt_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/ecmt_divider.sv */
// Restoring divider, one quotient bit a cycle.
// Used by the top level for centroid, variance and activity quotients.
module ecmt_divider #(
  parameter int NumW = 64,
  parameter int DenW = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic [NumW-1:0] quo,
  output logic [DenW-1:0] rem
);
  localparam int CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt;
  logic            busy;
  logic [NumW-1:0] q;
  logic [DenW:0]   r;
  logic [DenW-1:0] d;
  logic [DenW:0]   trial;
  logic [DenW:0]   shifted;

  always_comb begin
    shifted = {r[DenW-1:0], q[NumW-1]};
    trial   = shifted - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(NumW);
        q    <= num;
        r    <= '0;
        d    <= den;
      end else if (busy) begin
        if (!trial[DenW]) begin
          r <= trial;
          q <= {q[NumW-2:0], 1'b1};
        end else begin
          r <= shifted;
          q <= {q[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;
  assign rem = r[DenW-1:0];
endmodule

/* rtl/event_cluster_moment_tracker_core.sv */
// Top level of the event cluster moment tracker.
// Uses ecmt_pkg, ecmt_if and ecmt_divider.
//
//  channel   | role   | payload
//  in_ch     | sink   | func, timestamp, event_x, event_y
//  out_ch    | source | centroid, spread, activity, lifetime, path flag
//  cfg_*     | write  | min_activity_count, path_min_interval, path_max_dist_sq
//
// One item at a time. An event updates its activity slot, walks expired moment slots,
// updates its moment slot and sums the moment window; unless that is empty it divides
// for centroid and variance and takes square roots for the spread. A tick walks
// expired activity slots. Both sum the activity window and divide for the activity
// unless the window count is below the minimum; the divider is serial, one bit a
// cycle. After reset a clearing pass over max(MOMENT_SLOTS, ACTIVITY_SLOTS) slot
// indexes runs before the first item. A result waits in the output register while
// the next item is taken; that item's result is held back until the register frees.
module event_cluster_moment_tracker_core #(
  parameter int MOMENT_SLOTS     = ecmt_pkg::MomentSlots,
  parameter int ACTIVITY_SLOTS   = ecmt_pkg::ActivitySlots,
  parameter int MOMENT_SLOT_US   = ecmt_pkg::MomentSlotUs,
  parameter int ACTIVITY_SLOT_US = ecmt_pkg::ActivitySlotUs
) (
  input  logic                          clk,
  input  logic                          rst,
  ecmt_if.sink                          in_ch,
  ecmt_if.source                        out_ch,
  input  logic                          cfg_we,
  input  logic [ecmt_pkg::CfgAddrW-1:0] cfg_index,
  input  logic [ecmt_pkg::CfgDataW-1:0] cfg_data
);
  localparam int MW = $clog2(MOMENT_SLOTS);
  localparam int AW = $clog2(ACTIVITY_SLOTS);
  localparam int CW = ecmt_pkg::CoordBits;
  localparam int MaxSlots = (MOMENT_SLOTS > ACTIVITY_SLOTS) ? MOMENT_SLOTS : ACTIVITY_SLOTS;
  localparam int CLW = $clog2(MaxSlots + 1);

  // reciprocals for the slot divisions, exact over 31-bit timestamps
  localparam int MShift = 31 + $clog2(MOMENT_SLOT_US);
  localparam int AShift = 31 + $clog2(ACTIVITY_SLOT_US);
  localparam logic [31:0] MRecip =
    32'(((64'd1 << MShift) + 64'(MOMENT_SLOT_US) - 64'd1) / 64'(MOMENT_SLOT_US));
  localparam logic [31:0] ARecip =
    32'(((64'd1 << AShift) + 64'(ACTIVITY_SLOT_US) - 64'd1) / 64'(ACTIVITY_SLOT_US));

  typedef struct packed {
    logic [15:0] cnt;
    logic [23:0] sx;
    logic [23:0] sy;
    logic [31:0] sxx;
    logic [31:0] syy;
  } mom_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_IDX, S_AREAD, S_AWRITE, S_WALK, S_MREAD, S_MWRITE,
    S_SUM, S_SUMLAST, S_CX, S_CY, S_VX, S_VXQ, S_VXT, S_SQX, S_VY, S_VYQ,
    S_VYT, S_SQY, S_PATH, S_TSUM, S_TSUMLAST, S_ACT, S_ACTDIV, S_OUT
  } state_t;

  // ---------------- memories ----------------
  mom_t        mom_mem [MOMENT_SLOTS];
  logic [15:0] act_mem [ACTIVITY_SLOTS];
  logic        mom_we, act_we;
  logic [MW-1:0] mom_wa, mom_ra;
  logic [AW-1:0] act_wa, act_ra;
  mom_t        mom_wd, mom_rd;
  logic [15:0] act_wd, act_rd;

  always_ff @(posedge clk) begin
    if (mom_we) mom_mem[mom_wa] <= mom_wd;
    mom_rd <= mom_mem[mom_ra];
  end
  always_ff @(posedge clk) begin
    if (act_we) act_mem[act_wa] <= act_wd;
    act_rd <= act_mem[act_ra];
  end

  // ---------------- configuration ----------------
  logic [15:0] min_act;
  logic [19:0] path_int;
  logic [15:0] path_dsq;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_act  <= 16'd70;
      path_int <= 20'd20000;
      path_dsq <= 16'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ecmt_pkg::RegMinActivity:  min_act  <= cfg_data[15:0];
        ecmt_pkg::RegPathInterval: path_int <= cfg_data[19:0];
        ecmt_pkg::RegPathDistSq:   path_dsq <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- shared divider ----------------
  logic        div_start, div_done;
  logic [63:0] div_num, div_den, div_quo, div_rem;
  ecmt_divider #(.NumW(64), .DenW(64)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  // ---------------- state ----------------
  state_t           state;
  ecmt_pkg::in_item_t item;
  ecmt_pkg::out_item_t res;
  logic             out_valid;
  logic [CLW-1:0]   cnt;
  logic [30:0]      last_t, first_t, path_t;
  logic [14:0]      path_x, path_y, cur_cx, cur_cy, cx, cy;
  logic [15:0]      cur_sx, cur_sy, sx, sy;
  logic [MW-1:0]    midx, mlast, mwalk, lm_idx;
  logic [AW-1:0]    aidx, alast, awalk, la_idx;
  logic [MW+16:0]   n_sum;
  logic [MW+24:0]   s1x, s1y;
  logic [MW+32:0]   s2x, s2y;
  logic [AW+16:0]   a_sum;
  logic [63:0]      var_d, quo1;
  logic [63:0]      sq_v, sq_r, sq_b;
  logic [6:0]       sq_cnt;
  logic [63:0]      mul_a, mul_b;
  logic [1:0]       mul_ph;
  logic [63:0]      mul_p;
  logic             added;

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = res;

  // slot index of the item's time by reciprocal multiplication
  logic [62:0] tm_prod, ta_prod;
  logic [30:0] tm_div, ta_div;
  assign tm_prod = item.timestamp * MRecip;
  assign ta_prod = item.timestamp * ARecip;
  assign tm_div  = 31'(tm_prod >> MShift);
  assign ta_div  = 31'(ta_prod >> AShift);

  // squared coordinates
  logic [2*CW-1:0] ex2, ey2;
  assign ex2 = item.event_x * item.event_x;
  assign ey2 = item.event_y * item.event_y;

  // saturating slot update
  mom_t mom_upd;
  always_comb begin
    logic [16:0] c;
    logic [24:0] a, b;
    logic [32:0] e, f;
    c = {1'b0, mom_rd.cnt} + 17'd1;
    a = {1'b0, mom_rd.sx} + 25'(item.event_x);
    b = {1'b0, mom_rd.sy} + 25'(item.event_y);
    e = {1'b0, mom_rd.sxx} + 33'(ex2);
    f = {1'b0, mom_rd.syy} + 33'(ey2);
    mom_upd.cnt = c[16] ? 16'hFFFF : c[15:0];
    mom_upd.sx  = a[24] ? 24'hFFFFFF : a[23:0];
    mom_upd.sy  = b[24] ? 24'hFFFFFF : b[23:0];
    mom_upd.sxx = e[32] ? 32'hFFFFFFFF : e[31:0];
    mom_upd.syy = f[32] ? 32'hFFFFFFFF : f[31:0];
  end

  // path distance
  logic signed [16:0] dxs, dys;
  logic signed [33:0] dx2, dy2;
  logic [33:0] dd;
  logic signed [32:0] dt;
  assign dxs = $signed({2'b0, cx}) - $signed({2'b0, path_x});
  assign dys = $signed({2'b0, cy}) - $signed({2'b0, path_y});
  assign dx2 = dxs * dxs;
  assign dy2 = dys * dys;
  assign dd  = $unsigned(dx2) + $unsigned(dy2);
  assign dt  = $signed({2'b0, item.timestamp}) - $signed({2'b0, path_t});

  // products for variance and activity, one multiplier stepped over phases
  logic [63:0] mul_out;
  assign mul_out = mul_a[31:0] * mul_b[31:0];

  // integer square root step
  logic [63:0] sq_trial;
  assign sq_trial = sq_r + sq_b;

  logic [15:0] sq_clamp;
  assign sq_clamp = (sq_r[63:16] != 0) ? 16'hFFFF :
                    (sq_r[15:0] < 16'd256) ? 16'd256 : sq_r[15:0];

  always_comb begin
    mom_we = 1'b0; mom_wa = mwalk; mom_wd = '0; mom_ra = mwalk;
    act_we = 1'b0; act_wa = awalk; act_wd = '0; act_ra = awalk;
    unique case (state)
      S_CLEAR: begin
        mom_we = (cnt < CLW'(MOMENT_SLOTS));
        mom_wa = MW'(cnt);
        act_we = (cnt < CLW'(ACTIVITY_SLOTS));
        act_wa = AW'(cnt);
      end
      S_AREAD: act_ra = aidx;
      S_AWRITE: begin
        act_we = 1'b1; act_wa = aidx;
        act_wd = (aidx == alast) ? ((act_rd == 16'hFFFF) ? act_rd : act_rd + 16'd1)
                                 : 16'd1;
      end
      S_WALK: begin
        if (item.func == ecmt_pkg::FuncEvent) begin
          mom_we = (mwalk != midx); mom_wa = mwalk + 1'b1;
        end else begin
          act_we = (awalk != aidx); act_wa = awalk + 1'b1;
        end
      end
      S_MREAD: mom_ra = midx;
      S_MWRITE: begin
        mom_we = 1'b1; mom_wa = midx; mom_wd = mom_upd;
      end
      S_SUM: mom_ra = MW'(cnt);
      S_TSUM: act_ra = AW'(cnt);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      out_valid <= 1'b0;
      last_t <= '0; first_t <= '0; path_t <= '0;
      path_x <= '0; path_y <= '0;
      cur_cx <= '0; cur_cy <= '0; cur_sx <= '0; cur_sy <= '0;
      lm_idx <= '0; la_idx <= '0;
      mul_ph <= '0;
    end else begin
      // output register: load from the result state, clear on transfer
      if (state == S_OUT && (!out_valid || out_ch.ready)) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CLW'(MaxSlots - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          item  <= in_ch.data;
          state <= S_IDX;
        end
        S_IDX: begin
          midx  <= MW'(tm_div % 31'(MOMENT_SLOTS));
          mlast <= lm_idx;
          aidx  <= AW'(ta_div % 31'(ACTIVITY_SLOTS));
          alast <= la_idx;
          mwalk <= lm_idx;
          awalk <= la_idx;
          added <= 1'b0;
          if (item.func == ecmt_pkg::FuncEvent) begin
            state <= S_AREAD;
            if (first_t == '0) first_t <= item.timestamp;
          end else state <= S_WALK;
        end
        S_AREAD: state <= S_AWRITE;
        S_AWRITE: state <= S_WALK;
        // clear expired slots one per cycle
        S_WALK: begin
          if (item.func == ecmt_pkg::FuncEvent) begin
            if (mwalk == midx) state <= S_MREAD;
            else mwalk <= mwalk + 1'b1;
          end else begin
            if (awalk == aidx) begin
              state <= S_TSUM; cnt <= '0; a_sum <= '0;
              cx <= cur_cx; cy <= cur_cy;
              sx <= (cur_sx < 16'd256) ? 16'd256 : cur_sx;
              sy <= (cur_sy < 16'd256) ? 16'd256 : cur_sy;
            end else awalk <= awalk + 1'b1;
          end
        end
        S_MREAD: state <= S_MWRITE;
        S_MWRITE: begin
          state <= S_SUM; cnt <= '0;
          n_sum <= '0; s1x <= '0; s1y <= '0; s2x <= '0; s2y <= '0;
        end
        // window sums over a registered memory read
        S_SUM: begin
          if (cnt != '0) begin
            n_sum <= n_sum + (MW+17)'(mom_rd.cnt);
            s1x <= s1x + (MW+25)'(mom_rd.sx);
            s1y <= s1y + (MW+25)'(mom_rd.sy);
            s2x <= s2x + (MW+33)'(mom_rd.sxx);
            s2y <= s2y + (MW+33)'(mom_rd.syy);
          end
          if (cnt == CLW'(MOMENT_SLOTS)) state <= S_SUMLAST;
          else cnt <= cnt + 1'b1;
        end
        S_SUMLAST: begin
          mul_ph <= '0;
          if (n_sum == '0) begin
            cx <= '0; cy <= '0; sx <= 16'd256; sy <= 16'd256;
            state <= S_PATH;
          end else state <= S_CX;
        end
        S_CX, S_CY: begin
          if (mul_ph == 2'd0) begin
            mul_ph <= 2'd1;
          end else if (div_done) begin
            mul_ph <= 2'd0;
            if (state == S_CX) begin
              cx <= (div_quo > 64'd32767) ? 15'h7FFF : div_quo[14:0];
              state <= S_CY;
            end else begin
              cy <= (div_quo > 64'd32767) ? 15'h7FFF : div_quo[14:0];
              state <= S_VX;
            end
          end
        end
        // D = n*s2 - s1^2, clamped at zero, products over the multiplier phases
        S_VX, S_VY: begin
          unique case (mul_ph)
            2'd0: begin
              mul_a <= 64'(state == S_VX ? s1x : s1y);
              mul_b <= 64'(state == S_VX ? s1x : s1y);
              mul_ph <= 2'd1;
            end
            2'd1: begin
              mul_p <= mul_out;
              mul_a <= 64'(n_sum);
              mul_b <= 64'((state == S_VX ? s2x : s2y) >> 16);
              mul_ph <= 2'd2;
            end
            2'd2: begin
              var_d <= mul_out << 16;
              mul_b <= 64'((state == S_VX ? s2x : s2y) & 64'hFFFF);
              mul_ph <= 2'd3;
            end
            default: begin
              var_d <= ((var_d + mul_out) > mul_p) ? (var_d + mul_out - mul_p) : 64'd0;
              mul_ph <= 2'd0;
              state <= (state == S_VX) ? S_VXQ : S_VYQ;
            end
          endcase
        end
        // t = (d/n)<<18 + ((d%n)<<18)/n
        S_VXQ, S_VYQ: begin
          if (mul_ph == 2'd0) mul_ph <= 2'd1;
          else if (mul_ph == 2'd1 && div_done) begin
            quo1 <= div_quo << 18; mul_a <= div_rem << 18; mul_ph <= 2'd2;
          end else if (mul_ph == 2'd2) mul_ph <= 2'd3;
          else if (mul_ph == 2'd3 && div_done) begin
            quo1 <= quo1 + div_quo; mul_ph <= 2'd0;
            state <= (state == S_VXQ) ? S_VXT : S_VYT;
          end
        end
        S_VXT, S_VYT: begin
          if (mul_ph == 2'd0) mul_ph <= 2'd1;
          else if (div_done) begin
            sq_v <= div_quo; sq_r <= '0; sq_b <= 64'd1 << 62;
            sq_cnt <= 7'd32; mul_ph <= 2'd0;
            state <= (state == S_VXT) ? S_SQX : S_SQY;
          end
        end
        // bitwise square root, one result bit a cycle
        S_SQX, S_SQY: begin
          if (sq_cnt != 7'd0) begin
            if (sq_v >= sq_trial) begin
              sq_v <= sq_v - sq_trial;
              sq_r <= (sq_r >> 1) + sq_b;
            end else sq_r <= sq_r >> 1;
            sq_b <= sq_b >> 2;
            sq_cnt <= sq_cnt - 1'b1;
          end else if (state == S_SQX) begin
            sx <= sq_clamp; state <= S_VY;
          end else begin
            sy <= sq_clamp; state <= S_PATH;
          end
        end
        S_PATH: begin
          cur_cx <= cx; cur_cy <= cy; cur_sx <= sx; cur_sy <= sy;
          last_t <= item.timestamp;
          lm_idx <= midx;
          la_idx <= aidx;
          if (dt > $signed({13'b0, path_int}) || dd > {2'b0, path_dsq, 16'b0}) begin
            path_x <= cx; path_y <= cy; path_t <= item.timestamp;
            added <= 1'b1;
          end
          state <= S_TSUM; cnt <= '0; a_sum <= '0;
        end
        S_TSUM: begin
          if (cnt != '0) a_sum <= a_sum + (AW+17)'(act_rd);
          if (cnt == CLW'(ACTIVITY_SLOTS)) state <= S_TSUMLAST;
          else cnt <= cnt + 1'b1;
        end
        S_TSUMLAST: begin
          mul_a <= 64'(sx); mul_b <= 64'(sy);
          state <= S_ACT;
        end
        S_ACT: begin
          if (mul_ph == 2'd0) begin
            mul_a <= mul_out; mul_b <= 64'(ecmt_pkg::PiQ12); mul_ph <= 2'd1;
          end else begin
            mul_p <= mul_out; mul_ph <= 2'd0;
            state <= ((AW+17)'(min_act) > a_sum) ? S_OUT : S_ACTDIV;
            quo1 <= '0;
          end
        end
        S_ACTDIV: begin
          if (mul_ph == 2'd0) mul_ph <= 2'd1;
          else if (div_done) begin
            quo1 <= div_quo; mul_ph <= 2'd0; state <= S_OUT;
          end
        end
        S_OUT: if (!out_valid || out_ch.ready) begin
          res.centroid_x <= cx; res.centroid_y <= cy;
          res.spread_x <= sx; res.spread_y <= sy;
          res.activity <= (quo1 > 64'hFFFFFF) ? 24'hFFFFFF : quo1[23:0];
          res.lifetime <= item.timestamp - first_t;
          res.path_point_added <= added;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // divider operand selection; started in the first phase of each division
  always_comb begin
    div_num = '0;
    div_den = 64'd1;
    unique case (state)
      S_CX: begin div_num = 64'(s1x) << 8; div_den = 64'(n_sum); end
      S_CY: begin div_num = 64'(s1y) << 8; div_den = 64'(n_sum); end
      S_VXQ, S_VYQ: begin
        div_num = (mul_ph[1]) ? mul_a : var_d; div_den = 64'(n_sum);
      end
      S_VXT, S_VYT: begin div_num = quo1; div_den = 64'(n_sum); end
      S_ACTDIV: begin div_num = 64'(a_sum) << 36; div_den = mul_p; end
      default: ;
    endcase
    div_start = ((state == S_CX || state == S_CY || state == S_VXT || state == S_VYT ||
                  state == S_ACTDIV) && mul_ph == 2'd0) ||
                ((state == S_VXQ || state == S_VYQ) && (mul_ph == 2'd0 || mul_ph == 2'd2));
  end
endmodule
